>>> rtl/core/tpcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpcw_pkg;

	// Default page geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int CELLS_DEF   = 2000;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	typedef enum logic [2:0] {
		OP_PUT_CHAR   = 3'd0,
		OP_CLEAR_PAGE = 3'd1,
		OP_SET_COLUMN = 3'd2,
		OP_SET_ROW    = 3'd3,
		OP_SET_ABS    = 3'd4,
		OP_ADD_COLUMN = 3'd5,
		OP_SET_MODE   = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		MODE_CONSOLE    = 2'd0,
		MODE_CONSOLE_NL = 2'd1,
		MODE_PAGE       = 2'd2,
		MODE_PAGE_FROZEN = 2'd3
	} mode_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  char_code;
		logic [15:0] argument;
	} item_t;

	// Registered item with the argument already split by the column count
	typedef struct packed {
		logic        valid;
		item_t       item;
		logic [15:0] arg_quot;
	} stage_t;

endpackage

`default_nettype wire

>>> rtl/core/tpcw_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tpcw_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [7:0]  char_code;
	logic [15:0] argument;

	modport source (output valid, output operation, output char_code, output argument,
		input ready);
	modport sink (input valid, input operation, input char_code, input argument,
		output ready);
endinterface

`default_nettype wire

>>> rtl/core/tpcw_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tpcw_out_if #(
	parameter int PW = 11
);
	logic          valid;
	logic          ready;
	logic          console_valid;
	logic [7:0]    console_char;
	logic          cell_write;
	logic [PW-1:0] cell_address;
	logic [7:0]    cell_char;
	logic          clear_page;
	logic          page_updated;
	logic [PW-1:0] cursor_now;
	logic [1:0]    mode_now;

	modport source (output valid, output console_valid, output console_char,
		output cell_write, output cell_address, output cell_char, output clear_page,
		output page_updated, output cursor_now, output mode_now, input ready);
	modport sink (input valid, input console_valid, input console_char,
		input cell_write, input cell_address, input cell_char, input clear_page,
		input page_updated, input cursor_now, input mode_now, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tpcw_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module tpcw_in_stage import tpcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tpcw_in_if.sink   item,
	input  wire logic advance,
	output stage_t    stage
);

	// Exact floor(argument / COLUMNS) for a 16-bit argument by reciprocal multiply
	localparam int SH = 16 + $clog2(COLUMNS);
	localparam longint unsigned RECIP = ((64'd1 << SH) + COLUMNS - 1) / COLUMNS;
	localparam logic [16:0] RECIP_V = RECIP[16:0];

	logic [47:0] prod;
	logic        valid_s1;
	item_t       item_s1;
	logic [15:0] quot_s1;

	assign prod = 48'(item.argument) * 48'(RECIP_V);

	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.operation <= item.operation;
			item_s1.char_code <= item.char_code;
			item_s1.argument  <= item.argument;
			quot_s1           <= prod[SH +: 16];
		end
	end

	assign stage.valid    = valid_s1;
	assign stage.item     = item_s1;
	assign stage.arg_quot = quot_s1;

endmodule

`default_nettype wire

>>> rtl/core/tpcw_cursor_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tpcw_cursor_core import tpcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	parameter int CELLS   = CELLS_DEF,
	parameter int PW      = $clog2(CELLS_DEF + 1)
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire stage_t stage,
	output logic        advance,
	tpcw_out_if.source  result
);

	localparam int EW = (PW > 16 ? PW : 16) + 2;
	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS + 1);

	localparam logic [EW-1:0] COLS_E  = EW'(COLUMNS);
	localparam logic [EW-1:0] ROWS_E  = EW'(ROWS);
	localparam logic [EW-1:0] CELLS_E = EW'(CELLS);
	localparam logic [EW-1:0] LAST_E  = EW'(CELLS - 1);

	// Row base and column of the full-page and last-cell positions
	localparam logic [PW-1:0] FULL_BASE = PW'((CELLS / COLUMNS) * COLUMNS);
	localparam logic [CW-1:0] FULL_COL  = CW'(CELLS % COLUMNS);
	localparam logic [PW-1:0] LAST_BASE = PW'(((CELLS - 1) / COLUMNS) * COLUMNS);
	localparam logic [CW-1:0] LAST_COL  = CW'((CELLS - 1) % COLUMNS);

	// Cursor kept as position, row base and column: cur_q == base_q + col_q
	logic [PW-1:0] cur_q, base_q;
	logic [CW-1:0] col_q;
	mode_t         mode_q;

	logic [PW-1:0] nxt_cur, nxt_base;
	logic [CW-1:0] nxt_col;
	mode_t         nxt_mode;

	logic          out_free;
	logic          valid_q;
	logic          con_v_q, cw_q, clr_q, upd_q;
	logic [7:0]    con_c_q, cc_q;
	logic [PW-1:0] ca_q, cursor_q;
	logic [1:0]    mode_out_q;

	logic          con_v, cw, clr, upd;
	logic [7:0]    con_c, cc;
	logic [PW-1:0] ca;

	op_t           op;
	logic [7:0]    ch;
	logic [15:0]   arg;
	logic [EW-1:0] cur_e, base_e, col_e, arg_e, qc_e, rem_e;
	logic [EW-1:0] nl_e, setcol_e, rowb_e, setrow_e, sum_e, col2_e, addb_e;

	assign op  = op_t'(stage.item.operation);
	assign ch  = stage.item.char_code;
	assign arg = stage.item.argument;

	assign cur_e    = EW'(cur_q);
	assign base_e   = EW'(base_q);
	assign col_e    = EW'(col_q);
	assign arg_e    = EW'(arg);
	assign qc_e     = EW'(stage.arg_quot) * COLS_E;
	assign rem_e    = arg_e - qc_e;
	assign nl_e     = base_e + COLS_E;
	assign setcol_e = base_e + arg_e;
	assign rowb_e   = EW'(arg[RW-1:0]) * COLS_E;
	assign setrow_e = rowb_e + col_e;
	assign sum_e    = cur_e + arg_e;
	assign col2_e   = col_e + rem_e;
	assign addb_e   = base_e + qc_e;

	always_comb begin
		nxt_cur  = cur_q;
		nxt_base = base_q;
		nxt_col  = col_q;
		nxt_mode = mode_q;
		con_v    = 1'b0;
		con_c    = 8'd0;
		cw       = 1'b0;
		ca       = '0;
		cc       = 8'd0;
		clr      = 1'b0;
		upd      = 1'b0;
		case (op)
			OP_PUT_CHAR: begin
				if (mode_q == MODE_CONSOLE || mode_q == MODE_CONSOLE_NL) begin
					con_v = 1'b1;
					con_c = ch;
				end else if (cur_e < CELLS_E) begin
					if (ch != NEWLINE_CODE) begin
						cw      = 1'b1;
						ca      = cur_q;
						cc      = ch;
						nxt_cur = PW'(cur_e + EW'(1));
						if (col_e + EW'(1) == COLS_E) begin
							nxt_col  = '0;
							nxt_base = PW'(nl_e);
						end else begin
							nxt_col = CW'(col_e + EW'(1));
						end
					end else if (nl_e > CELLS_E) begin
						nxt_cur  = PW'(CELLS_E);
						nxt_base = FULL_BASE;
						nxt_col  = FULL_COL;
					end else begin
						nxt_cur  = PW'(nl_e);
						nxt_base = PW'(nl_e);
						nxt_col  = '0;
					end
					upd = (mode_q == MODE_PAGE);
				end
			end
			OP_CLEAR_PAGE: begin
				clr = 1'b1;
				upd = 1'b1;
			end
			OP_SET_COLUMN: begin
				if (arg_e < COLS_E) begin
					if (setcol_e > CELLS_E) begin
						nxt_cur  = PW'(CELLS_E);
						nxt_base = FULL_BASE;
						nxt_col  = FULL_COL;
					end else begin
						nxt_cur = PW'(setcol_e);
						nxt_col = arg[CW-1:0];
					end
				end
			end
			OP_SET_ROW: begin
				if (arg_e < ROWS_E) begin
					if (setrow_e > CELLS_E) begin
						nxt_cur  = PW'(CELLS_E);
						nxt_base = FULL_BASE;
						nxt_col  = FULL_COL;
					end else begin
						nxt_cur  = PW'(setrow_e);
						nxt_base = PW'(rowb_e);
					end
				end
			end
			OP_SET_ABS: begin
				if (arg_e < CELLS_E) begin
					nxt_cur  = PW'(arg_e);
					nxt_base = PW'(qc_e);
					nxt_col  = CW'(rem_e);
				end
			end
			OP_ADD_COLUMN: begin
				if (sum_e > LAST_E) begin
					nxt_cur  = PW'(LAST_E);
					nxt_base = LAST_BASE;
					nxt_col  = LAST_COL;
				end else begin
					nxt_cur = PW'(sum_e);
					// carry the column into the row base
					if (col2_e >= COLS_E) begin
						nxt_col  = CW'(col2_e - COLS_E);
						nxt_base = PW'(addb_e + COLS_E);
					end else begin
						nxt_col  = CW'(col2_e);
						nxt_base = PW'(addb_e);
					end
				end
			end
			OP_SET_MODE: begin
				if (arg_e <= EW'(3)) begin
					nxt_mode = mode_t'(arg[1:0]);
				end
				upd = (arg_e == EW'(MODE_PAGE));
			end
			default: begin
			end
		endcase
	end

	assign out_free = !valid_q || result.ready;
	assign advance  = stage.valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			base_q  <= '0;
			col_q   <= '0;
			mode_q  <= MODE_CONSOLE;
			valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				valid_q <= stage.valid;
			end
			if (advance) begin
				cur_q  <= nxt_cur;
				base_q <= nxt_base;
				col_q  <= nxt_col;
				mode_q <= nxt_mode;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			con_v_q    <= con_v;
			con_c_q    <= con_c;
			cw_q       <= cw;
			ca_q       <= ca;
			cc_q       <= cc;
			clr_q      <= clr;
			upd_q      <= upd;
			cursor_q   <= nxt_cur;
			mode_out_q <= nxt_mode;
		end
	end

	assign result.valid         = valid_q;
	assign result.console_valid = con_v_q;
	assign result.console_char  = con_c_q;
	assign result.cell_write    = cw_q;
	assign result.cell_address  = ca_q;
	assign result.cell_char     = cc_q;
	assign result.clear_page    = clr_q;
	assign result.page_updated  = upd_q;
	assign result.cursor_now    = cursor_q;
	assign result.mode_now      = mode_out_q;

endmodule

`default_nettype wire

>>> rtl/core/text_page_cursor_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Beat contents
// item     in   operation, char_code, argument
// result   out  console, page cell write, clear/update flags, cursor_now, mode_now
//
// One beat in per cycle while the result is not stalled, one result per item; an item
// passes the item register, then the output register. The item register splits the
// argument by the column count with a reciprocal multiply; the cursor stage updates
// position, row base and column. Reset puts the cursor at cell 0 in console mode.
// A stalled result holds in the output register while the item register takes one
// more beat only if it is empty.

module text_page_cursor_writer import tpcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	parameter int CELLS   = CELLS_DEF,
	parameter int PW      = $clog2(CELLS + 1)
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tpcw_in_if.sink    item,
	tpcw_out_if.source result
);

	stage_t stage;
	logic   advance;

	tpcw_in_stage #(
		.COLUMNS (COLUMNS)
	) u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.advance (advance),
		.stage   (stage)
	);

	tpcw_cursor_core #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.CELLS   (CELLS),
		.PW      (PW)
	) u_cursor_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.advance (advance),
		.result  (result)
	);

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import tpcw_pkg::*;

	// Operation code that the block treats as a no-op
	localparam logic [2:0] OP_RESERVED = 3'd7;
	localparam int QUIET_LIMIT = 1000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic        console_valid;
		logic [7:0]  console_char;
		logic        cell_write;
		logic [10:0] cell_address;
		logic [7:0]  cell_char;
		logic        clear_page;
		logic        page_updated;
		logic [10:0] cursor_now;
		logic [1:0]  mode_now;
	} page_result_t;

	logic clk = 1'b0;
	logic arst_n;

	tpcw_in_if item_ch ();
	tpcw_out_if #(.PW(11)) result_ch ();

	text_page_cursor_writer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int unsigned  cursor_model;
	mode_t        mode_model;
	page_result_t pending_results[$];
	int           mismatch_count;
	int           quiet_cycles;
	bit           idle_enabled;

	function automatic int unsigned clamp_to_page(int unsigned pos);
		return (pos > CELLS_DEF) ? CELLS_DEF : pos;
	endfunction

	// Advance the cursor/mode model by one item and return the result it causes
	function automatic page_result_t predict_result(logic [2:0] op, logic [7:0] ch,
			logic [15:0] arg);
		page_result_t r;
		int unsigned  sum;
		r = '0;
		case (op)
			OP_PUT_CHAR: begin
				if (mode_model == MODE_CONSOLE || mode_model == MODE_CONSOLE_NL) begin
					r.console_valid = 1'b1;
					r.console_char  = ch;
				end else if (cursor_model < CELLS_DEF) begin
					if (ch != NEWLINE_CODE) begin
						r.cell_write   = 1'b1;
						r.cell_address = 11'(cursor_model);
						r.cell_char    = ch;
						cursor_model++;
					end else begin
						cursor_model = clamp_to_page(
							(cursor_model / COLUMNS_DEF + 1) * COLUMNS_DEF);
					end
					r.page_updated = (mode_model == MODE_PAGE);
				end
			end
			OP_CLEAR_PAGE: begin
				r.clear_page   = 1'b1;
				r.page_updated = 1'b1;
			end
			OP_SET_COLUMN: begin
				if (arg < COLUMNS_DEF)
					cursor_model = clamp_to_page(
						(cursor_model / COLUMNS_DEF) * COLUMNS_DEF + arg);
			end
			OP_SET_ROW: begin
				if (arg < ROWS_DEF)
					cursor_model = clamp_to_page(
						cursor_model % COLUMNS_DEF + arg * COLUMNS_DEF);
			end
			OP_SET_ABS: begin
				if (arg < CELLS_DEF)
					cursor_model = arg;
			end
			OP_ADD_COLUMN: begin
				// saturate one short of full, even when starting from a full page
				sum = cursor_model + arg;
				cursor_model = (sum > CELLS_DEF - 1) ? CELLS_DEF - 1 : sum;
			end
			OP_SET_MODE: begin
				if (arg <= 16'(MODE_PAGE_FROZEN))
					mode_model = mode_t'(arg[1:0]);
				r.page_updated = (arg == 16'(MODE_PAGE));
			end
			default: ;
		endcase
		r.cursor_now = 11'(cursor_model);
		r.mode_now   = mode_model;
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
	endtask

	// Checker: compare each result beat with the oldest prediction
	always @(posedge clk) begin : check_results
		page_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("result beat with no prediction pending");
			end else begin
				want = pending_results.pop_front();
				if (result_ch.console_valid !== want.console_valid)
					note_mismatch("console_valid", want.console_valid, result_ch.console_valid);
				if (result_ch.console_char !== want.console_char)
					note_mismatch("console_char", want.console_char, result_ch.console_char);
				if (result_ch.cell_write !== want.cell_write)
					note_mismatch("cell_write", want.cell_write, result_ch.cell_write);
				if (result_ch.cell_address !== want.cell_address)
					note_mismatch("cell_address", want.cell_address, result_ch.cell_address);
				if (result_ch.cell_char !== want.cell_char)
					note_mismatch("cell_char", want.cell_char, result_ch.cell_char);
				if (result_ch.clear_page !== want.clear_page)
					note_mismatch("clear_page", want.clear_page, result_ch.clear_page);
				if (result_ch.page_updated !== want.page_updated)
					note_mismatch("page_updated", want.page_updated, result_ch.page_updated);
				if (result_ch.cursor_now !== want.cursor_now)
					note_mismatch("cursor_now", want.cursor_now, result_ch.cursor_now);
				if (result_ch.mode_now !== want.mode_now)
					note_mismatch("mode_now", want.mode_now, result_ch.mode_now);
			end
		end
	end

	// Watchdog: end the run when no beat moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Result sink: when idle_enabled is set, stall a random number of cycles before taking each beat
	initial begin : result_sink
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = idle_enabled ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat
	task automatic send_item(logic [2:0] op, logic [7:0] ch, logic [15:0] arg);
		int gap;
		gap = idle_enabled ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.operation <= op;
		item_ch.char_code <= ch;
		item_ch.argument  <= arg;
		do @(posedge clk); while (!item_ch.ready);
		pending_results.push_back(predict_result(op, ch, arg));
		@(negedge clk);
	endtask

	// Hold the sender until every predicted result has come back
	task automatic drain_results;
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_console_output;
		send_item(OP_PUT_CHAR, 8'h00, 16'h0000);
		send_item(OP_PUT_CHAR, 8'hFF, 16'hFFFF);
		send_item(OP_PUT_CHAR, NEWLINE_CODE, 16'h0000);
		send_item(OP_SET_MODE, 8'h00, 16'(MODE_CONSOLE_NL));
		send_item(OP_PUT_CHAR, NEWLINE_CODE, 16'h0000);
	endtask

	task automatic test_page_writes;
		send_item(OP_SET_MODE, 8'h00, 16'(MODE_PAGE));
		send_item(OP_PUT_CHAR, 8'h41, 16'h0000);
		send_item(OP_PUT_CHAR, NEWLINE_CODE, 16'h0000);
		send_item(OP_SET_MODE, 8'h00, 16'(MODE_PAGE_FROZEN));
		send_item(OP_PUT_CHAR, 8'h42, 16'h0000);
		send_item(OP_SET_MODE, 8'h00, 16'hFFFF);
	endtask

	task automatic test_cursor_commands;
		send_item(OP_SET_COLUMN, 8'h00, 16'(COLUMNS_DEF));
		send_item(OP_SET_COLUMN, 8'h00, 16'(COLUMNS_DEF - 1));
		send_item(OP_SET_ROW, 8'h00, 16'(ROWS_DEF));
		send_item(OP_SET_ROW, 8'h00, 16'(ROWS_DEF - 1));
		send_item(OP_SET_ABS, 8'h00, 16'hFFFF);
		send_item(OP_SET_ABS, 8'h00, 16'h0000);
		send_item(OP_ADD_COLUMN, 8'h00, 16'hFFFF);
		send_item(OP_CLEAR_PAGE, 8'hFF, 16'hFFFF);
		send_item(OP_RESERVED, 8'hFF, 16'hFFFF);
	endtask

	task automatic test_page_full;
		send_item(OP_SET_MODE, 8'h00, 16'(MODE_PAGE));
		send_item(OP_SET_ABS, 8'h00, 16'(CELLS_DEF - 50));
		send_item(OP_PUT_CHAR, NEWLINE_CODE, 16'h0000);  // last row: newline lands on full page
		send_item(OP_PUT_CHAR, 8'h78, 16'h0000);         // dropped, page full
		send_item(OP_SET_COLUMN, 8'h00, 16'd3);
		send_item(OP_ADD_COLUMN, 8'h00, 16'h0000);
		send_item(OP_PUT_CHAR, 8'hFF, 16'h0000);
	endtask

	function automatic logic [15:0] draw_argument(int unsigned span);
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, span));
	endfunction

	// Mostly characters, with enough repositioning to reach the page end often
	task automatic test_random_traffic(int count);
		int unsigned pick;
		logic [7:0]  ch;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			ch = ($urandom_range(0, 7) == 0) ? NEWLINE_CODE : 8'($urandom);
			if (pick < 60)
				send_item(OP_PUT_CHAR, ch, 16'($urandom));
			else if (pick < 63)
				send_item(OP_CLEAR_PAGE, ch, 16'($urandom));
			else if (pick < 68)
				send_item(OP_SET_COLUMN, ch, draw_argument(COLUMNS_DEF - 1));
			else if (pick < 73)
				send_item(OP_SET_ROW, ch, draw_argument(ROWS_DEF - 1));
			else if (pick < 80)
				send_item(OP_SET_ABS, ch, ($urandom_range(0, 1) == 0) ?
					16'($urandom_range(CELLS_DEF - 100, CELLS_DEF - 1)) :
					draw_argument(CELLS_DEF - 1));
			else if (pick < 86)
				send_item(OP_ADD_COLUMN, ch, draw_argument(120));
			else if (pick < 97)
				send_item(OP_SET_MODE, ch, draw_argument(3));
			else
				send_item(OP_RESERVED, ch, 16'($urandom));
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.operation   = '0;
		item_ch.char_code   = '0;
		item_ch.argument    = '0;
		cursor_model        = 0;
		mode_model          = MODE_CONSOLE;
		mismatch_count      = 0;
		quiet_cycles        = 0;
		idle_enabled        = 1'b1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_console_output();
		test_page_writes();
		test_cursor_commands();
		test_page_full();
		test_random_traffic(400);
		drain_results();
		idle_enabled = 1'b0;
		test_random_traffic(200);
		idle_enabled = 1'b1;
		drain_results();
		test_random_traffic(425);

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/tpcw_pkg.sv
rtl/core/tpcw_in_if.sv
rtl/core/tpcw_out_if.sv
rtl/core/tpcw_in_stage.sv
rtl/core/tpcw_cursor_core.sv
rtl/core/text_page_cursor_writer.sv
sim/testbench.sv
